FILE: design/local_conditional_mutual_information_macros.svh
// Assertion macros for the local conditional mutual information block.
// Used by the top level; define NO_ASSERTIONS to drop every check.
`ifndef LOCAL_CONDITIONAL_MUTUAL_INFORMATION_MACROS_SVH
`define LOCAL_CONDITIONAL_MUTUAL_INFORMATION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LCMI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lcmi assertion failed");
`define LCMI_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("lcmi assertion failed");
`else
`define LCMI_ASSERT(name, prop)
`define LCMI_ASSERT_ALWAYS(name, prop)
`endif
`endif

FILE: design/lcmi_pkg.sv
// Package for the local conditional mutual information block.
// Holds sizes, request modes and sequencer states; no dependencies.
package lcmi_pkg;
  localparam int unsigned XBits     = 4;
  localparam int unsigned YBits     = 4;
  localparam int unsigned ZBits     = 4;
  localparam int unsigned CountBits = 20;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned XyzBits   = XBits + YBits + ZBits;
  localparam int unsigned XzBits    = XBits + ZBits;
  localparam int unsigned YzBits    = YBits + ZBits;
  localparam int unsigned EBits     = $clog2(CountBits);
  localparam int unsigned StepBits  = $clog2(FracBits);
  localparam int unsigned TermBits  = EBits + FracBits;
  localparam int unsigned ValueBits = 23;
  localparam int unsigned SumBits   = ValueBits + 1;
  localparam int unsigned MantBits  = 63;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_READ, ST_LOADWR, ST_LOGINIT,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_ACCUM, ST_FINISH
  } state_e;
endpackage

FILE: design/local_conditional_mutual_information.sv
// Local conditional mutual information over four count stores, top level.
// Depends on lcmi_pkg and local_conditional_mutual_information_macros.svh.
//
// Input stream: tuser carries the mode (load, query, clear), tdata the
// x, y and z symbols. A load bumps four saturating counts. A clear zeroes
// all stores by a sweep over the joint entries (one joint entry per
// cycle). A query reads the counts, then evaluates four log2 terms on one
// shared 32x32 multiplier: each fraction bit squares the 63-bit mantissa in
// three partial products plus one combine step. A query with a zero count
// skips the terms. The output stream carries the signed Q.16 value in
// tdata and the defined flag in tuser. After reset the block runs the same
// clearing sweep with tready low. A finished result sits in the output
// register; a new request is taken while it waits, but the next query
// result holds in the final state until the receiver takes the previous
// one.
`include "local_conditional_mutual_information_macros.svh"
module local_conditional_mutual_information import lcmi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // x_symbol[3:0], y_symbol[7:4], z_symbol[11:8]
  input  logic [1:0]  s_axis_tuser_i,  // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // local_value[22:0]
  output logic        m_axis_tuser_o   // defined[0]
);
  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic signed [SumBits-1:0] Lim = SumBits'((2 * CountBits) << FracBits);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic [XyzBits-1:0] ixyz_q, ixyz_d, clr_q, clr_d;
  logic [XzBits-1:0]  ixz;
  logic [YzBits-1:0]  iyz;
  logic [ZBits-1:0]   iz;

  logic [CountBits-1:0] joint_mem [2**XyzBits];
  logic [CountBits-1:0] xz_mem    [2**XzBits];
  logic [CountBits-1:0] yz_mem    [2**YzBits];
  logic [CountBits-1:0] z_mem     [2**ZBits];
  logic [CountBits-1:0] rd_xyz_q, rd_xz_q, rd_yz_q, rd_z_q;
  logic                 we;
  logic [XyzBits-1:0]   wa_xyz;
  logic [XzBits-1:0]    wa_xz;
  logic [YzBits-1:0]    wa_yz;
  logic [ZBits-1:0]     wa_z;
  logic [CountBits-1:0] wd_xyz, wd_xz, wd_yz, wd_z;

  logic [1:0]           term_q, term_d;
  logic [StepBits-1:0]  step_q, step_d;
  logic [EBits-1:0]     e_q, e_d, e_n;
  logic [FracBits-1:0]  frac_q, frac_d;
  logic [MantBits-1:0]  m_q, m_d;
  logic [63:0]          p0_q, p0_d, p1_q, p1_d, p2_q, p2_d, prod;
  logic [31:0]          mul_a, mul_b;
  logic [127:0]         sq;
  logic [63:0]          mn;
  logic [CountBits-1:0] cnt_sel;
  logic signed [SumBits-1:0] sum_q, sum_d;
  logic                 any_zero;

  logic                 ov_q, ov_d, odef_q, odef_d;
  logic [ValueBits-1:0] oval_q, oval_d;

  assign ixz = {ixyz_q[XyzBits-1 -: XBits], ixyz_q[ZBits-1:0]};
  assign iyz = ixyz_q[YzBits-1:0];
  assign iz  = ixyz_q[ZBits-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      joint_mem[wa_xyz] <= wd_xyz;
      xz_mem[wa_xz]     <= wd_xz;
      yz_mem[wa_yz]     <= wd_yz;
      z_mem[wa_z]       <= wd_z;
    end
    rd_xyz_q <= joint_mem[ixyz_q];
    rd_xz_q  <= xz_mem[ixz];
    rd_yz_q  <= yz_mem[iyz];
    rd_z_q   <= z_mem[iz];
  end

  assign any_zero = (rd_xyz_q == '0) || (rd_xz_q == '0) || (rd_yz_q == '0) ||
                    (rd_z_q == '0);

  // Term order: xyz and z add, xz and yz subtract.
  always_comb begin
    case (term_q)
      2'd0:    cnt_sel = rd_xyz_q;
      2'd1:    cnt_sel = rd_z_q;
      2'd2:    cnt_sel = rd_xz_q;
      default: cnt_sel = rd_yz_q;
    endcase
  end

  always_comb begin
    e_n = '0;
    for (int i = 1; i < CountBits; i++) begin
      if (cnt_sel[i]) e_n = EBits'(i);
    end
  end

  always_comb begin
    case (state_q)
      ST_MUL1: begin mul_a = m_q[31:0]; mul_b = {1'b0, m_q[62:32]}; end
      ST_MUL2: begin mul_a = {1'b0, m_q[62:32]}; mul_b = {1'b0, m_q[62:32]}; end
      default: begin mul_a = m_q[31:0]; mul_b = m_q[31:0]; end
    endcase
  end
  assign prod = mul_a * mul_b;
  assign sq   = {p2_q, 64'd0} + {31'd0, p1_q, 33'd0} + {64'd0, p0_q};
  assign mn   = sq[125:62];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          case (mode_e'(s_axis_tuser_i))
            MODE_LOAD, MODE_QUERY: state_d = ST_READ;
            MODE_CLEAR:            state_d = ST_CLEAR;
            default:               state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:   if (clr_q == '1) state_d = ST_IDLE;
      ST_READ:    state_d = (mode_q == MODE_LOAD) ? ST_LOADWR : ST_LOGINIT;
      ST_LOADWR:  state_d = ST_IDLE;
      ST_LOGINIT: state_d = any_zero ? ST_FINISH : ST_MUL0;
      ST_MUL0:    state_d = ST_MUL1;
      ST_MUL1:    state_d = ST_MUL2;
      ST_MUL2:    state_d = ST_ACCUM;
      ST_ACCUM: begin
        if (step_q != StepBits'(FracBits - 1)) state_d = ST_MUL0;
        else if (term_q == 2'd3)               state_d = ST_FINISH;
        else                                   state_d = ST_LOGINIT;
      end
      ST_FINISH:  if (!ov_q || m_axis_tready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    mode_d = mode_q;
    ixyz_d = ixyz_q;
    clr_d  = clr_q;
    term_d = term_q;
    step_d = step_q;
    e_d    = e_q;
    frac_d = frac_q;
    m_d    = m_q;
    p0_d   = p0_q;
    p1_d   = p1_q;
    p2_d   = p2_q;
    sum_d  = sum_q;
    ov_d   = ov_q && !m_axis_tready_i;
    oval_d = oval_q;
    odef_d = odef_q;
    we     = 1'b0;
    wa_xyz = clr_q;
    wa_xz  = clr_q[XzBits-1:0];
    wa_yz  = clr_q[YzBits-1:0];
    wa_z   = clr_q[ZBits-1:0];
    wd_xyz = '0;
    wd_xz  = '0;
    wd_yz  = '0;
    wd_z   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          mode_d = mode_e'(s_axis_tuser_i);
          ixyz_d = {s_axis_tdata_i[XBits-1:0], s_axis_tdata_i[4 +: YBits],
                    s_axis_tdata_i[8 +: ZBits]};
          clr_d  = '0;
          term_d = '0;
          sum_d  = '0;
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      ST_LOADWR: begin
        // Bump each count, hold at full scale.
        we     = 1'b1;
        wa_xyz = ixyz_q;
        wa_xz  = ixz;
        wa_yz  = iyz;
        wa_z   = iz;
        wd_xyz = (rd_xyz_q == CountMax) ? rd_xyz_q : rd_xyz_q + 1'b1;
        wd_xz  = (rd_xz_q  == CountMax) ? rd_xz_q  : rd_xz_q  + 1'b1;
        wd_yz  = (rd_yz_q  == CountMax) ? rd_yz_q  : rd_yz_q  + 1'b1;
        wd_z   = (rd_z_q   == CountMax) ? rd_z_q   : rd_z_q   + 1'b1;
      end
      ST_LOGINIT: begin
        e_d    = e_n;
        m_d    = MantBits'({{(MantBits - CountBits){1'b0}}, cnt_sel}
                 << (MantBits - 1 - 32'(e_n)));
        step_d = '0;
        frac_d = '0;
      end
      ST_MUL0: p0_d = prod;
      ST_MUL1: p1_d = prod;
      ST_MUL2: p2_d = prod;
      ST_ACCUM: begin
        frac_d = {frac_q[FracBits-2:0], mn[63]};
        m_d    = mn[63] ? mn[63:1] : mn[62:0];
        step_d = step_q + 1'b1;
        if (step_q == StepBits'(FracBits - 1)) begin
          term_d = term_q + 1'b1;
          sum_d  = (term_q[1] == 1'b0) ?
                   sum_q + SumBits'({e_q, frac_d}) : sum_q - SumBits'({e_q, frac_d});
        end
      end
      ST_FINISH: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d = 1'b1;
          if (mode_q != MODE_QUERY || any_zero) begin
            oval_d = '0;
            odef_d = 1'b0;
          end else begin
            odef_d = 1'b1;
            if (sum_q > Lim)       oval_d = Lim[ValueBits-1:0];
            else if (sum_q < -Lim) oval_d = ValueBits'(-Lim);
            else                   oval_d = sum_q[ValueBits-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
      mode_q  <= MODE_NONE;
      term_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      mode_q  <= mode_d;
      term_q  <= term_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ixyz_q <= ixyz_d;
    e_q    <= e_d;
    frac_q <= frac_d;
    m_q    <= m_d;
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    sum_q  <= sum_d;
    oval_q <= oval_d;
    odef_q <= odef_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {1'b0, oval_q};
  assign m_axis_tuser_o  = odef_q;

  `LCMI_ASSERT(ready_only_idle, s_axis_tready_o |-> state_q == ST_IDLE)
  `LCMI_ASSERT_ALWAYS(no_accept_clearing, state_q == ST_CLEAR |-> !s_axis_tready_o)
  `LCMI_ASSERT(result_from_finish, $rose(m_axis_tvalid_o) |-> $past(state_q) == ST_FINISH)
  `LCMI_ASSERT(undef_is_zero, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
endmodule
